### rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the UTF-8 validator.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BUV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BUV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/buv_pkg.sv
// Package for the UTF-8 validator: byte classes, error codes, the queued
// transaction type and the code point bounds. Depends on nothing.
`default_nettype none

package buv_pkg;

  localparam int unsigned LEN_W = 16;
  localparam int unsigned CP_W  = 21;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 16'd255;

  localparam logic [CP_W-1:0] CP_MIN_2B   = 21'h00080;
  localparam logic [CP_W-1:0] CP_MIN_3B   = 21'h00800;
  localparam logic [CP_W-1:0] CP_MIN_4B   = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h0D800;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h0DFFF;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_class_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TOO_LONG  = 3'd1,
    ERR_BAD_LEAD  = 3'd2,
    ERR_BAD_CONT  = 3'd3,
    ERR_TRUNCATED = 3'd4,
    ERR_OVERLONG  = 3'd5,
    ERR_RANGE     = 3'd6,
    ERR_SURROGATE = 3'd7
  } err_t;

  // One classified transaction. The payload holds the data bits of the
  // byte with its tag already removed.
  typedef struct packed {
    logic        empty;
    logic        last;
    byte_class_t cls;
    logic [6:0]  bits;
  } item_t;

endpackage

`default_nettype wire

### rtl/buv_front.sv
// Front end of the UTF-8 validator: accepts input transactions and
// classifies each byte. Depends on buv_pkg.
`default_nettype none

module buv_front
  import buv_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last,
  input  wire logic       in_empty_text,
  input  wire logic       q_full,
  output logic            q_push,
  output item_t           q_item
);

  byte_class_t cls;
  logic [6:0]  bits;

  always_comb begin
    if (!in_data_byte[7]) begin
      cls  = CLS_ASCII;
      bits = in_data_byte[6:0];
    end else if (in_data_byte[7:6] == 2'b10) begin
      cls  = CLS_CONT;
      bits = {1'b0, in_data_byte[5:0]};
    end else if (in_data_byte[7:5] == 3'b110) begin
      cls  = CLS_LEAD2;
      bits = {2'b00, in_data_byte[4:0]};
    end else if (in_data_byte[7:4] == 4'b1110) begin
      cls  = CLS_LEAD3;
      bits = {3'b000, in_data_byte[3:0]};
    end else if (in_data_byte[7:3] == 5'b11110) begin
      cls  = CLS_LEAD4;
      bits = {4'b0000, in_data_byte[2:0]};
    end else begin
      cls  = CLS_BAD;
      bits = 7'd0;
    end
  end

  assign in_stall     = q_full;
  assign q_push       = in_valid && !q_full;
  assign q_item.empty = in_empty_text;
  assign q_item.last  = in_last;
  assign q_item.cls   = cls;
  assign q_item.bits  = bits;

endmodule

`default_nettype wire

### rtl/buv_queue.sv
// Short queue of classified transactions between front and back end.
// Depends on buv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module buv_queue
  import buv_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output item_t      head_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `BUV_ASSERT_NOW(a_q_no_overflow, 1'b1, cnt_r <= CNT_FULL, "queue count above depth")
  `BUV_ASSERT_NOW(a_q_pop_nonempty, pop, cnt_r != '0, "queue popped while empty")
  `BUV_ASSERT_NOW(a_q_push_room, push && !pop, cnt_r != CNT_FULL, "queue pushed while full")

endmodule

`default_nettype wire

### rtl/buv_back.sv
// Back end of the UTF-8 validator: per-text decode state, length limit,
// error capture and the result register. Depends on buv_pkg and
// assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module buv_back
  import buv_pkg::*;
#(
  parameter int unsigned LENGTH_LIMIT_TOP = 65535
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [LEN_W-1:0] cfg_wr_data,
  input  wire logic             q_valid,
  input  wire item_t            q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_valid_res,
  output logic [2:0]            out_error_code,
  output logic [LEN_W-1:0]      out_text_length
);

  localparam logic [LEN_W-1:0] COUNT_TOP = LEN_W'(LENGTH_LIMIT_TOP);

  logic [LEN_W-1:0] max_len_r;
  logic [1:0]       pend_r, pend_upd, pend_nxt;
  logic [1:0]       seq_r, seq_upd, seq_nxt;
  logic [CP_W-1:0]  cp_r, cp_upd, cp_nxt, cp_shift;
  logic [LEN_W-1:0] cnt_r, cnt_upd, cnt_nxt, limit;
  logic             exc_r, exc_upd, exc_nxt;
  err_t             err_r, err_upd, err_nxt;
  err_t             res_code;
  logic             ends_text;
  logic             out_free;
  logic             out_valid_r, out_valid_nxt;
  logic             res_valid_r;
  err_t             res_code_r;
  logic [LEN_W-1:0] res_len_r;

  assign limit     = (max_len_r < COUNT_TOP) ? max_len_r : COUNT_TOP;
  assign ends_text = q_item.empty || q_item.last;
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && (!ends_text || out_free);
  assign cp_shift  = {cp_r[CP_W-7:0], q_item.bits[5:0]};

  always_comb begin
    pend_upd = pend_r;
    seq_upd  = seq_r;
    cp_upd   = cp_r;
    cnt_upd  = cnt_r;
    exc_upd  = exc_r;
    err_upd  = err_r;
    if (q_pop && !q_item.empty) begin
      if (cnt_r >= COUNT_TOP) begin
        exc_upd = 1'b1;
      end else begin
        cnt_upd = LEN_W'(cnt_r + 1'b1);
        if (cnt_upd > limit) begin
          exc_upd = 1'b1;
        end
      end
      if (err_r == ERR_NONE) begin
        if (pend_r == 2'd0) begin
          unique case (q_item.cls)
            CLS_ASCII: begin
              seq_upd = 2'd0;
              cp_upd  = CP_W'(q_item.bits);
            end
            CLS_LEAD2: begin
              seq_upd  = 2'd1;
              pend_upd = 2'd1;
              cp_upd   = CP_W'(q_item.bits[4:0]);
            end
            CLS_LEAD3: begin
              seq_upd  = 2'd2;
              pend_upd = 2'd2;
              cp_upd   = CP_W'(q_item.bits[3:0]);
            end
            CLS_LEAD4: begin
              seq_upd  = 2'd3;
              pend_upd = 2'd3;
              cp_upd   = CP_W'(q_item.bits[2:0]);
            end
            default: begin
              err_upd = ERR_BAD_LEAD;
            end
          endcase
        end else if (q_item.cls != CLS_CONT) begin
          err_upd = ERR_BAD_CONT;
        end else begin
          cp_upd   = cp_shift;
          pend_upd = 2'(pend_r - 1'b1);
          if (pend_r == 2'd1) begin
            if ((seq_r == 2'd1 && cp_shift < CP_MIN_2B) ||
                (seq_r == 2'd2 && cp_shift < CP_MIN_3B) ||
                (seq_r == 2'd3 && cp_shift < CP_MIN_4B)) begin
              err_upd = ERR_OVERLONG;
            end else if (cp_shift > CP_MAX) begin
              err_upd = ERR_RANGE;
            end else if (cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI) begin
              err_upd = ERR_SURROGATE;
            end
          end
        end
      end
    end

    if (exc_upd) begin
      res_code = ERR_TOO_LONG;
    end else if (err_upd != ERR_NONE) begin
      res_code = err_upd;
    end else if (pend_upd != 2'd0) begin
      res_code = ERR_TRUNCATED;
    end else begin
      res_code = ERR_NONE;
    end

    if (q_pop && ends_text) begin
      pend_nxt = 2'd0;
      seq_nxt  = 2'd0;
      cp_nxt   = '0;
      cnt_nxt  = '0;
      exc_nxt  = 1'b0;
      err_nxt  = ERR_NONE;
    end else begin
      pend_nxt = pend_upd;
      seq_nxt  = seq_upd;
      cp_nxt   = cp_upd;
      cnt_nxt  = cnt_upd;
      exc_nxt  = exc_upd;
      err_nxt  = err_upd;
    end

    if (q_pop && ends_text) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= MAX_LENGTH_RST;
      pend_r      <= 2'd0;
      seq_r       <= 2'd0;
      cp_r        <= '0;
      cnt_r       <= '0;
      exc_r       <= 1'b0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      pend_r      <= pend_nxt;
      seq_r       <= seq_nxt;
      cp_r        <= cp_nxt;
      cnt_r       <= cnt_nxt;
      exc_r       <= exc_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && ends_text) begin
      res_valid_r <= (res_code == ERR_NONE);
      res_code_r  <= res_code;
      res_len_r   <= cnt_upd;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = res_valid_r;
  assign out_error_code  = res_code_r;
  assign out_text_length = res_len_r;

  `BUV_ASSERT_NOW(a_pend_within_seq, 1'b1, pend_r <= seq_r, "pending count above sequence length")
  `BUV_ASSERT_NOW(a_cnt_saturates, 1'b1, cnt_r <= COUNT_TOP, "byte count above its top")
  `BUV_ASSERT_NEXT(a_result_held, out_valid_r && out_stall, out_valid_r && $stable(res_code_r),
    "stalled result lost or changed")

endmodule

`default_nettype wire

### rtl/bounded_utf8_validator.sv
// Top level of the bounded UTF-8 validator: front end, queue and back end.
// Depends on buv_pkg, buv_front, buv_queue and buv_back.
//
//   Channel  Handshake            Payload
//   in_      in_valid/in_stall    in_data_byte, in_last, in_empty_text
//   out_     out_valid/out_stall  out_valid_res, out_error_code, out_text_length
//   cfg_     cfg_wr_en            cfg_wr_data (max_length)
//
// One byte transaction is accepted per cycle while the queue has room.
// out_valid rises after the final transaction of a text is accepted: the item is
// written into the queue, then popped by the back end, which registers the result.
// The queue of QUEUE_DEPTH entries absorbs output stalls; in_stall rises when it fills.
// Reset is synchronous and active low; it sets max_length to 255 and clears all text state.
`default_nettype none

module bounded_utf8_validator
  import buv_pkg::*;
#(
  parameter int unsigned LENGTH_LIMIT_TOP = 65535,
  parameter int unsigned QUEUE_DEPTH      = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [LEN_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_last,
  input  wire logic             in_empty_text,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_valid_res,
  output logic [2:0]            out_error_code,
  output logic [LEN_W-1:0]      out_text_length
);

  item_t push_item;
  item_t head_item;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;

  buv_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last       (in_last),
    .in_empty_text (in_empty_text),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  buv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  buv_back #(
    .LENGTH_LIMIT_TOP (LENGTH_LIMIT_TOP)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .q_valid         (q_valid),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_valid_res   (out_valid_res),
    .out_error_code  (out_error_code),
    .out_text_length (out_text_length)
  );

endmodule

`default_nettype wire

### dv/bounded_utf8_validator_tb.sv
// Testbench for bounded_utf8_validator: directed and random texts are checked
// against a behavioral UTF-8 checker held in a small scoreboard class.
// Depends on buv_pkg and the bounded_utf8_validator RTL.
`default_nettype none

module bounded_utf8_validator_tb
  import buv_pkg::*;
();

  typedef struct packed {
    logic        ok;
    err_t        code;
    logic [15:0] len;
  } text_result_t;

  class utf8_scoreboard;
    localparam logic [15:0] LEN_TOP      = 16'hFFFF;
    localparam logic [20:0] LOW_2BYTE    = 21'h000080;
    localparam logic [20:0] LOW_3BYTE    = 21'h000800;
    localparam logic [20:0] LOW_4BYTE    = 21'h010000;
    localparam logic [20:0] TOP_CODE     = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST   = 21'h00D800;
    localparam logic [20:0] SURR_LAST    = 21'h00DFFF;

    logic [15:0]  limit_reg;
    logic [1:0]   cont_left;
    logic [1:0]   seq_conts;
    logic [20:0]  cp_acc;
    logic [15:0]  byte_cnt;
    logic         too_long;
    err_t         first_err;
    text_result_t expected_q[$];
    int           failures;

    function new();
      limit_reg = 16'd255;
      failures  = 0;
      clear_text();
    endfunction

    function void clear_text();
      cont_left = '0;
      seq_conts = '0;
      cp_acc    = '0;
      byte_cnt  = '0;
      too_long  = 1'b0;
      first_err = ERR_NONE;
    endfunction

    function void note_input(logic [7:0] b, logic lst, logic emp);
      text_result_t res;
      if (!emp) begin
        if (byte_cnt == LEN_TOP) begin
          too_long = 1'b1;
        end else begin
          byte_cnt = byte_cnt + 16'd1;
          if (byte_cnt > limit_reg) too_long = 1'b1;
        end
        if (first_err == ERR_NONE) begin
          if (cont_left == 2'd0) begin
            if (b[7] == 1'b0) begin
              seq_conts = 2'd0;
              cp_acc = {14'd0, b[6:0]};
            end else if (b[7:5] == 3'b110) begin
              seq_conts = 2'd1;
              cont_left = 2'd1;
              cp_acc = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
              seq_conts = 2'd2;
              cont_left = 2'd2;
              cp_acc = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
              seq_conts = 2'd3;
              cont_left = 2'd3;
              cp_acc = {18'd0, b[2:0]};
            end else begin
              first_err = ERR_BAD_LEAD;
            end
          end else if (b[7:6] != 2'b10) begin
            first_err = ERR_BAD_CONT;
          end else begin
            cp_acc = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
              if ((seq_conts == 2'd1 && cp_acc < LOW_2BYTE) ||
                  (seq_conts == 2'd2 && cp_acc < LOW_3BYTE) ||
                  (seq_conts == 2'd3 && cp_acc < LOW_4BYTE))
                first_err = ERR_OVERLONG;
              else if (cp_acc > TOP_CODE)
                first_err = ERR_RANGE;
              else if (cp_acc >= SURR_FIRST && cp_acc <= SURR_LAST)
                first_err = ERR_SURROGATE;
            end
          end
        end
      end
      if (emp || lst) begin
        if (too_long) res.code = ERR_TOO_LONG;
        else if (first_err != ERR_NONE) res.code = first_err;
        else if (cont_left != 2'd0) res.code = ERR_TRUNCATED;
        else res.code = ERR_NONE;
        res.ok  = (res.code == ERR_NONE);
        res.len = byte_cnt;
        expected_q.push_back(res);
        clear_text();
      end
    endfunction

    function void check_result(logic ok, logic [2:0] code, logic [15:0] len);
      text_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: valid_res=%0b error_code=%0d text_length=%0d",
                   ok, code, len);
        return;
      end
      want = expected_q.pop_front();
      if (ok !== want.ok || code !== want.code || len !== want.len) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected valid_res=%0b error_code=%0d text_length=%0d, %s%0b %s%0d %s%0d",
                   want.ok, want.code, want.len, "got valid_res=", ok,
                   "error_code=", code, "text_length=", len);
      end
    endfunction
  endclass

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_mode_t;
  typedef enum int {
    FAULT_TRUNCATE, FAULT_SWAP_BYTE, FAULT_STRAY_CONT, FAULT_OVERLONG,
    FAULT_SURROGATE, FAULT_ABOVE_RANGE, FAULT_BAD_LEAD, FAULT_C0_C1
  } fault_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last = 1'b0;
  logic        in_empty_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_valid_res;
  logic [2:0]  out_error_code;
  logic [15:0] out_text_length;

  utf8_scoreboard sb = new();
  logic [7:0]     text_bytes[$];
  int             burst_left = 0;
  stall_mode_t    stall_mode = STALL_NONE;
  int             stall_run = 0;
  bit             stall_level = 1'b0;
  logic [7:0]     mode_cycles = '0;

  bounded_utf8_validator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last         (in_last),
    .in_empty_text   (in_empty_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_valid_res   (out_valid_res),
    .out_error_code  (out_error_code),
    .out_text_length (out_text_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    mode_cycles = mode_cycles + 8'd1;
    if (mode_cycles == 8'd0) stall_mode = stall_mode_t'($urandom_range(0, 2));
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_SPARSE: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (stall_run == 0) begin
          stall_level = !stall_level;
          stall_run = $urandom_range(1, 24);
        end
        stall_run--;
        out_stall <= stall_level;
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_valid_res, out_error_code, out_text_length);
  end

  task automatic send_item(input logic [7:0] b, input logic lst, input logic emp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_last       <= lst;
    in_empty_text <= emp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b, lst, emp);
  endtask

  task automatic send_text(input bit end_empty);
    int n;
    n = text_bytes.size();
    for (int i = 0; i < n; i++)
      send_item(text_bytes[i], !end_empty && (i == n - 1), 1'b0);
    if (end_empty || n == 0)
      send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_max_length(input logic [15:0] v);
    wait_all_results();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.limit_reg = v;
  endtask

  function automatic void push_seq(input logic [20:0] cp, input int n);
    case (n)
      1: text_bytes.push_back({1'b0, cp[6:0]});
      2: text_bytes.push_back({3'b110, cp[10:6]});
      3: text_bytes.push_back({4'b1110, cp[15:12]});
      default: text_bytes.push_back({5'b11110, cp[20:18]});
    endcase
    for (int i = n - 2; i >= 0; i--) text_bytes.push_back({2'b10, cp[6*i +: 6]});
  endfunction

  // Mostly well-formed texts with random content, some with one fault added,
  // the rest random noise and empty texts.
  task automatic run_random_texts(input int n_items);
    int          sent;
    int          kind;
    int          n;
    int          last_n;
    logic [20:0] cp;
    logic [20:0] bound;
    bit          end_empty;
    sent = 0;
    while (sent < n_items) begin
      text_bytes.delete();
      kind = $urandom_range(0, 99);
      last_n = 1;
      if (kind >= 8 && kind < 20) begin
        repeat ($urandom_range(1, 10)) text_bytes.push_back(8'($urandom));
      end else if (kind >= 20) begin
        repeat ($urandom_range(1, 8)) begin
          last_n = $urandom_range(1, 4);
          case (last_n)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3: begin
              cp = 21'($urandom_range('h800, 'hFFFF));
              if (cp >= 'hD800 && cp <= 'hDFFF && $urandom_range(0, 3) != 0)
                cp = cp ^ 21'h2000;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
          endcase
          push_seq(cp, last_n);
        end
        if ($urandom_range(0, 3) == 0) begin
          case (fault_t'($urandom_range(0, 7)))
            FAULT_TRUNCATE: begin
              if (last_n > 1) repeat ($urandom_range(1, last_n - 1)) void'(text_bytes.pop_back());
            end
            FAULT_SWAP_BYTE: begin
              text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom);
            end
            FAULT_STRAY_CONT: begin
              text_bytes.insert($urandom_range(0, text_bytes.size() - 1),
                                {2'b10, 6'($urandom)});
            end
            FAULT_OVERLONG: begin
              n = $urandom_range(2, 4);
              bound = (n == 2) ? 21'h80 : (n == 3) ? 21'h800 : 21'h10000;
              push_seq(21'($urandom_range(0, bound - 1)), n);
            end
            FAULT_SURROGATE: push_seq(21'($urandom_range('hD800, 'hDFFF)), 3);
            FAULT_ABOVE_RANGE: push_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            FAULT_BAD_LEAD: text_bytes.push_back({5'b11111, 3'($urandom)});
            default: begin
              text_bytes.push_back({7'b1100000, 1'($urandom)});
              text_bytes.push_back({2'b10, 6'($urandom)});
            end
          endcase
        end
      end
      end_empty = (text_bytes.size() == 0) || ($urandom_range(0, 9) == 0);
      send_text(end_empty);
      sent += text_bytes.size() + int'(end_empty);
      if ($urandom_range(0, 40) == 0) wait_all_results();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    text_bytes = '{8'h00, 8'h7F};               send_text(1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    text_bytes = '{8'hC1, 8'hBF};               send_text(1'b0);
    text_bytes = '{8'hED, 8'hA0, 8'h80};        send_text(1'b0);
    text_bytes = '{8'hF5, 8'h80, 8'h80, 8'h80}; send_text(1'b0);
    text_bytes = '{8'hFF};                      send_text(1'b0);
    text_bytes = '{8'hC3, 8'h41};               send_text(1'b0);
    text_bytes = '{8'hE2, 8'h82};               send_text(1'b0);
    text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_text(1'b0);
    text_bytes = '{8'h41};                      send_text(1'b1);

    set_max_length(16'd0);
    run_random_texts(100);
    set_max_length(16'hFFFF);
    run_random_texts(300);
    set_max_length(16'd1);
    run_random_texts(100);
    set_max_length(16'($urandom_range(2, 24)));
    run_random_texts(300);
    set_max_length(16'($urandom));
    run_random_texts(200);
    set_max_length(16'd12);
    run_random_texts(200);

    wait_all_results();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/buv_pkg.sv
rtl/buv_front.sv
rtl/buv_queue.sv
rtl/buv_back.sv
rtl/bounded_utf8_validator.sv
dv/bounded_utf8_validator_tb.sv
